### src/pump_occlusion_detector_core_defines.svh
// Assertion macros for the pump occlusion detector.
// Depends on nothing; taken in by pump_occlusion_detector_core, which carries the assertions.
`ifndef PUMP_OCCLUSION_DETECTOR_CORE_DEFINES_SVH
`define PUMP_OCCLUSION_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define POD_ASSERT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define POD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

### src/pod_pkg.sv
// Shared types and constants for the pump occlusion detector.
// Depends on nothing; used by pump_occlusion_detector_core and its test bench.
package pod_pkg;

  localparam int CFG_WIDTH   = 24;
  localparam int FLOW_WIDTH  = 16;
  localparam int CTIME_WIDTH = 16;
  localparam int ARM_WIDTH   = 8;
  localparam int THR_WIDTH   = 24;
  localparam int CIDX_WIDTH  = 3;

  localparam logic [ARM_WIDTH-1:0] RISE_MAX = '1;

  // Register indexes of the configuration port
  typedef enum logic [CIDX_WIDTH-1:0] {
    CFG_LOW_FLOW_LIMIT      = 3'd0,
    CFG_HIGH_FLOW_LIMIT     = 3'd1,
    CFG_SAMPLE_INTERVAL     = 3'd2,
    CFG_RISE_ARM_COUNT      = 3'd3,
    CFG_SLOW_RISE_THRESHOLD = 3'd4,
    CFG_FAST_RISE_THRESHOLD = 3'd5,
    CFG_FAST_WINDOW         = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [FLOW_WIDTH-1:0]  low_flow_limit;
    logic [FLOW_WIDTH-1:0]  high_flow_limit;
    logic [CTIME_WIDTH-1:0] sample_interval;
    logic [ARM_WIDTH-1:0]   rise_arm_count;
    logic [THR_WIDTH-1:0]   slow_rise_threshold;
    logic [THR_WIDTH-1:0]   fast_rise_threshold;
    logic [CTIME_WIDTH-1:0] fast_window;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    low_flow_limit:      16'd1000,
    high_flow_limit:     16'd20000,
    sample_interval:     16'd100,
    rise_arm_count:      8'd60,
    slow_rise_threshold: 24'd800,
    fast_rise_threshold: 24'd800,
    fast_window:         16'd1500
  };

endpackage

### src/pump_occlusion_detector_core.sv
// Pump occlusion and locked-rotor detector, top level.
// Depends on pod_pkg and pump_occlusion_detector_core_defines.svh.
//
// An accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle unless out_stall holds a full output; the state
// update and all compares sit between the detector state and output registers.
// Reset: rst (synchronous, active high) clears all detector state and the output
// valid, and loads the configuration registers with their default values.
`include "pump_occlusion_detector_core_defines.svh"

module pump_occlusion_detector_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TICK_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [pod_pkg::CIDX_WIDTH-1:0]   cfg_index,
  input  logic [pod_pkg::CFG_WIDTH-1:0]    cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_WIDTH-1:0]          pressure_sample,
  input  logic [pod_pkg::FLOW_WIDTH-1:0]   set_flow,
  input  logic                             motor_enabled,
  input  logic                             calibrating,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             lock_flag,
  output logic                             stop_motor,
  output logic                             bridge_hiz
);

  // Widths at which ticks and rises meet the fixed-width registers
  localparam int TCMP_W = (TICK_WIDTH > pod_pkg::CTIME_WIDTH) ? TICK_WIDTH
                                                              : pod_pkg::CTIME_WIDTH;
  localparam int DCMP_W = (SAMPLE_WIDTH > pod_pkg::THR_WIDTH) ? SAMPLE_WIDTH
                                                              : pod_pkg::THR_WIDTH;

  pod_pkg::cfg_regs_t cfg;

  // Detector state
  logic [TICK_WIDTH-1:0]         tick_count,       tick_count_next;
  logic [SAMPLE_WIDTH-1:0]       previous_sample,  previous_sample_next;
  logic [SAMPLE_WIDTH-1:0]       reference_sample, reference_sample_next;
  logic [pod_pkg::ARM_WIDTH-1:0] rise_count,       rise_count_next;
  logic                          fast_armed,       fast_armed_next;
  logic                          lock_state,       lock_state_next;
  logic                          stop_next, hiz_next;

  logic                          accept;
  logic [TICK_WIDTH-1:0]         tick_inc;
  logic [pod_pkg::ARM_WIDTH-1:0] rise_inc;
  logic [SAMPLE_WIDTH-1:0]       slow_diff, fast_diff;
  logic                          run_ok, slow_mode, fast_mode;
  logic                          slow_due, slow_rise, fast_rise, fast_in_window;

  // Accept a new request whenever the output register is free or being emptied
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pod_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (pod_pkg::cfg_index_t'(cfg_index))
        pod_pkg::CFG_LOW_FLOW_LIMIT:
          cfg.low_flow_limit <= cfg_data[pod_pkg::FLOW_WIDTH-1:0];
        pod_pkg::CFG_HIGH_FLOW_LIMIT:
          cfg.high_flow_limit <= cfg_data[pod_pkg::FLOW_WIDTH-1:0];
        pod_pkg::CFG_SAMPLE_INTERVAL:
          cfg.sample_interval <= cfg_data[pod_pkg::CTIME_WIDTH-1:0];
        pod_pkg::CFG_RISE_ARM_COUNT:
          cfg.rise_arm_count <= cfg_data[pod_pkg::ARM_WIDTH-1:0];
        pod_pkg::CFG_SLOW_RISE_THRESHOLD:
          cfg.slow_rise_threshold <= cfg_data[pod_pkg::THR_WIDTH-1:0];
        pod_pkg::CFG_FAST_RISE_THRESHOLD:
          cfg.fast_rise_threshold <= cfg_data[pod_pkg::THR_WIDTH-1:0];
        pod_pkg::CFG_FAST_WINDOW:
          cfg.fast_window <= cfg_data[pod_pkg::CTIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Tick counter advances every request, holding at its maximum
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign rise_inc = (rise_count == pod_pkg::RISE_MAX) ? rise_count : rise_count + 1'b1;

  // Mode selection: slow takes precedence over fast
  assign run_ok    = motor_enabled && !calibrating;
  assign slow_mode = run_ok && (set_flow < cfg.low_flow_limit);
  assign fast_mode = run_ok && !slow_mode && (set_flow < cfg.high_flow_limit);

  // Rise tests; a fall never counts, so the difference matters only when positive.
  // The reference can only be retaken when the count equals the arm count, which
  // excludes the lock compare, so the held reference is the right one to use.
  assign slow_due  = TCMP_W'(tick_inc) > TCMP_W'(cfg.sample_interval);
  assign slow_diff = pressure_sample - reference_sample;
  assign fast_diff = pressure_sample - previous_sample;
  assign slow_rise = (pressure_sample > reference_sample) &&
                     (DCMP_W'(slow_diff) > DCMP_W'(cfg.slow_rise_threshold));
  assign fast_rise = (pressure_sample > previous_sample) &&
                     (DCMP_W'(fast_diff) > DCMP_W'(cfg.fast_rise_threshold));
  assign fast_in_window = TCMP_W'(tick_inc) < TCMP_W'(cfg.fast_window);

  always_comb begin
    tick_count_next       = tick_inc;
    previous_sample_next  = previous_sample;
    reference_sample_next = reference_sample;
    rise_count_next       = rise_count;
    fast_armed_next       = fast_armed;
    lock_state_next       = lock_state;
    stop_next             = 1'b0;
    hiz_next              = 1'b0;

    if (slow_mode) begin
      if (slow_due) begin
        tick_count_next = '0;
        if (pressure_sample > previous_sample) begin
          rise_count_next = rise_inc;
          if (rise_inc == cfg.rise_arm_count) begin
            reference_sample_next = pressure_sample;
          end
          if ((rise_inc > cfg.rise_arm_count) && slow_rise) begin
            lock_state_next = 1'b1;
            stop_next       = 1'b1;
          end else begin
            lock_state_next = 1'b0;
          end
          previous_sample_next = pressure_sample;
        end else if (pressure_sample < previous_sample) begin
          // a fall restarts the run of rises and keeps the lock as it is
          rise_count_next      = '0;
          previous_sample_next = pressure_sample;
        end
      end
    end else if (fast_mode) begin
      if (!fast_armed) begin
        // take the baseline and restart the window
        previous_sample_next = pressure_sample;
        fast_armed_next      = 1'b1;
        tick_count_next      = '0;
      end else if (fast_rise && fast_in_window) begin
        lock_state_next = 1'b1;
        stop_next       = 1'b1;
        hiz_next        = 1'b1;
        fast_armed_next = 1'b0;
      end
    end
  end

  // Detector state, updated once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      previous_sample  <= '0;
      reference_sample <= '0;
      rise_count       <= '0;
      fast_armed       <= 1'b0;
      lock_state       <= 1'b0;
    end else if (accept) begin
      tick_count       <= tick_count_next;
      previous_sample  <= previous_sample_next;
      reference_sample <= reference_sample_next;
      rise_count       <= rise_count_next;
      fast_armed       <= fast_armed_next;
      lock_state       <= lock_state_next;
    end
  end

  // Output register: load on accept, drop once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lock_flag  <= lock_state_next;
      stop_motor <= stop_next;
      bridge_hiz <= hiz_next;
    end
  end

  `POD_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid, "accepted request produced no result")
  `POD_ASSERT(a_stop_means_lock, clk, rst, out_valid && stop_motor, lock_flag, "stop pulse without lock flag")
  `POD_ASSERT(a_hiz_means_stop, clk, rst, out_valid && bridge_hiz, stop_motor, "bridge high impedance without stop pulse")
  `POD_ASSERT(a_disarm_on_trip, clk, rst, $fell(fast_armed) && !$past(rst), out_valid && bridge_hiz, "fast detector disarmed without a trip")

endmodule

### tb/pump_occlusion_detector_core_test.sv
// Self-checking bench for pump_occlusion_detector_core: one result per tick request.
// Depends on pod_pkg and the core; directed table, fixed-setting runs, then random phases.
// Results are checked against typed script flags or a cycle-free detector model here.
module pump_occlusion_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = 24;
  localparam int TICK_W   = 16;

  typedef struct packed {
    logic [SAMPLE_W-1:0]            pressure;
    logic [pod_pkg::FLOW_WIDTH-1:0] flow;
    logic                           motor;
    logic                           calib;
  } request_t;

  typedef struct packed {
    logic lock;
    logic stop;
    logic hiz;
  } outcome_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} step_kind_t;

  // One line of the directed script: either a register write or a tick request.
  // Where typed is set, flags holds the outcome read straight off the behaviour.
  typedef struct packed {
    step_kind_t                     kind;
    pod_pkg::cfg_index_t            reg_sel;
    logic [pod_pkg::CFG_WIDTH-1:0]  value;
    logic [SAMPLE_W-1:0]            pressure;
    logic [pod_pkg::FLOW_WIDTH-1:0] flow;
    logic                           motor;
    logic                           calib;
    logic                           typed;
    outcome_t                       flags;
  } script_row_t;

  // Register field of a tick row, which no write uses
  localparam pod_pkg::cfg_index_t NO_REG = pod_pkg::CFG_LOW_FLOW_LIMIT;

  localparam int SCRIPT_ROWS = 28;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // defaults after reset: low 1000, high 20000, interval 100, arm 60, thresholds 800
    '{ROW_TICK,  NO_REG, 24'd0, 24'd0,       16'd0,     1'b0, 1'b0, 1'b1, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'hFFFFFF,  16'hFFFF,  1'b1, 1'b0, 1'b1, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd1000,    16'd5000,  1'b1, 1'b1, 1'b1, 3'b000},
    // fast mode: baseline, rise equal to the threshold, then one above it
    '{ROW_TICK,  NO_REG, 24'd0, 24'd1000,    16'd5000,  1'b1, 1'b0, 1'b1, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd1800,    16'd19999, 1'b1, 1'b0, 1'b1, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd1801,    16'd1000,  1'b1, 1'b0, 1'b1, 3'b111},
    // re-arm keeps the lock; full-scale rise trips again
    '{ROW_TICK,  NO_REG, 24'd0, 24'd0,       16'd5000,  1'b1, 1'b0, 1'b1, 3'b100},
    '{ROW_TICK,  NO_REG, 24'd0, 24'hFFFFFF,  16'd5000,  1'b1, 1'b0, 1'b1, 3'b111},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd5,       16'd20000, 1'b1, 1'b0, 1'b1, 3'b100},
    // slow mode with a compare every other tick, arm at the first rise
    '{ROW_WRITE, pod_pkg::CFG_SAMPLE_INTERVAL,     24'd1, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 3'b000},
    '{ROW_WRITE, pod_pkg::CFG_RISE_ARM_COUNT,      24'd1, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 3'b000},
    '{ROW_WRITE, pod_pkg::CFG_SLOW_RISE_THRESHOLD, 24'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd10,      16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd20,      16'd999,   1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd20,      16'd999,   1'b1, 1'b0, 1'b0, 3'b000},
    // equal sample, then a fall, then a fresh rise that re-arms
    '{ROW_TICK,  NO_REG, 24'd0, 24'd20,      16'd999,   1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd20,      16'd999,   1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd5,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd5,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd6,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd6,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    // arm count of zero: the reference is never retaken
    '{ROW_WRITE, pod_pkg::CFG_RISE_ARM_COUNT,      24'd0, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd7,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd7,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    // arm count at its top value
    '{ROW_WRITE, pod_pkg::CFG_RISE_ARM_COUNT,      24'd255, 24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd9,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd9,       16'd0,     1'b1, 1'b0, 1'b0, 3'b000},
    '{ROW_TICK,  NO_REG, 24'd0, 24'd9,       16'd0,     1'b0, 1'b1, 1'b0, 3'b000}
  };

  logic                           clk;
  logic                           rst             = 1'b1;
  logic                           cfg_write       = 1'b0;
  pod_pkg::cfg_index_t            cfg_index       = pod_pkg::CFG_LOW_FLOW_LIMIT;
  logic [pod_pkg::CFG_WIDTH-1:0]  cfg_data        = '0;
  logic                           in_valid        = 1'b0;
  logic                           in_stall;
  logic [SAMPLE_W-1:0]            pressure_sample = '0;
  logic [pod_pkg::FLOW_WIDTH-1:0] set_flow        = '0;
  logic                           motor_enabled   = 1'b0;
  logic                           calibrating     = 1'b0;
  logic                           out_valid;
  logic                           out_stall       = 1'b0;
  logic                           lock_flag;
  logic                           stop_motor;
  logic                           bridge_hiz;

  pump_occlusion_detector_core #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .TICK_WIDTH(TICK_W)
  ) DUT (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pressure_sample, .set_flow, .motor_enabled, .calibrating,
    .out_valid, .out_stall, .lock_flag, .stop_motor, .bridge_hiz
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #30ms;
    $display("** pump_occlusion_detector_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Detector model: register copy and state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  pod_pkg::cfg_regs_t  detector_regs = pod_pkg::CFG_RESET;
  logic [TICK_W-1:0]   ticks_since   = '0;
  logic [SAMPLE_W-1:0] last_pressure = '0;
  logic [SAMPLE_W-1:0] ref_pressure  = '0;
  logic [7:0]          rises         = '0;
  logic                baseline_held = 1'b0;
  logic                locked        = 1'b0;

  outcome_t pending_flags [$];
  int       mismatches = 0;

  // A fall can never exceed a threshold, so test the order first.
  function automatic bit climbs_past(logic [SAMPLE_W-1:0] now, logic [SAMPLE_W-1:0] base,
                                     logic [pod_pkg::THR_WIDTH-1:0] thr);
    return (now > base) && ((now - base) > thr);
  endfunction

  function automatic outcome_t advance_detector(request_t rq);
    outcome_t o;
    logic     running;
    o = '0;
    running = rq.motor && !rq.calib;
    if (ticks_since != '1) ticks_since++;
    if (running && rq.flow < detector_regs.low_flow_limit) begin
      // slow mode: one compare per interval
      if (ticks_since > detector_regs.sample_interval) begin
        ticks_since = '0;
        if (rq.pressure > last_pressure) begin
          if (rises != pod_pkg::RISE_MAX) rises++;
          if (rises == detector_regs.rise_arm_count) ref_pressure = rq.pressure;
          if (rises > detector_regs.rise_arm_count &&
              climbs_past(rq.pressure, ref_pressure, detector_regs.slow_rise_threshold)) begin
            locked = 1'b1;
            o.stop = 1'b1;
          end else begin
            locked = 1'b0;
          end
          last_pressure = rq.pressure;
        end else if (rq.pressure < last_pressure) begin
          rises = '0;
          last_pressure = rq.pressure;
        end
      end
    end else if (running && rq.flow < detector_regs.high_flow_limit) begin
      // fast mode: baseline once, then watch the window
      if (!baseline_held) begin
        last_pressure = rq.pressure;
        baseline_held = 1'b1;
        ticks_since = '0;
      end else if (climbs_past(rq.pressure, last_pressure, detector_regs.fast_rise_threshold) &&
                   ticks_since < detector_regs.fast_window) begin
        locked = 1'b1;
        o.stop = 1'b1;
        o.hiz = 1'b1;
        baseline_held = 1'b0;
      end
    end
    o.lock = locked;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: bursts of back-to-back requests separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  task automatic offer_tick(request_t rq, bit typed, outcome_t typed_flags);
    outcome_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    end
    if (gap_left != 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    burst_left--;
    in_valid <= 1'b1;
    pressure_sample <= rq.pressure;
    set_flow <= rq.flow;
    motor_enabled <= rq.motor;
    calibrating <= rq.calib;
    // hold the request until the core takes it
    do @(posedge clk); while (in_stall);
    predicted = advance_detector(rq);
    pending_flags.push_back(typed ? typed_flags : predicted);
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic put_register(pod_pkg::cfg_index_t sel, logic [pod_pkg::CFG_WIDTH-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      pod_pkg::CFG_LOW_FLOW_LIMIT:
        detector_regs.low_flow_limit = val[pod_pkg::FLOW_WIDTH-1:0];
      pod_pkg::CFG_HIGH_FLOW_LIMIT:
        detector_regs.high_flow_limit = val[pod_pkg::FLOW_WIDTH-1:0];
      pod_pkg::CFG_SAMPLE_INTERVAL:
        detector_regs.sample_interval = val[pod_pkg::CTIME_WIDTH-1:0];
      pod_pkg::CFG_RISE_ARM_COUNT:
        detector_regs.rise_arm_count = val[pod_pkg::ARM_WIDTH-1:0];
      pod_pkg::CFG_SLOW_RISE_THRESHOLD:
        detector_regs.slow_rise_threshold = val[pod_pkg::THR_WIDTH-1:0];
      pod_pkg::CFG_FAST_RISE_THRESHOLD:
        detector_regs.fast_rise_threshold = val[pod_pkg::THR_WIDTH-1:0];
      pod_pkg::CFG_FAST_WINDOW:
        detector_regs.fast_window = val[pod_pkg::CTIME_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(pod_pkg::cfg_regs_t s);
    settle();
    put_register(pod_pkg::CFG_LOW_FLOW_LIMIT, s.low_flow_limit);
    put_register(pod_pkg::CFG_HIGH_FLOW_LIMIT, s.high_flow_limit);
    put_register(pod_pkg::CFG_SAMPLE_INTERVAL, s.sample_interval);
    put_register(pod_pkg::CFG_RISE_ARM_COUNT, s.rise_arm_count);
    put_register(pod_pkg::CFG_SLOW_RISE_THRESHOLD, s.slow_rise_threshold);
    put_register(pod_pkg::CFG_FAST_RISE_THRESHOLD, s.fast_rise_threshold);
    put_register(pod_pkg::CFG_FAST_WINDOW, s.fast_window);
    cfg_write <= 1'b0;
  endtask

  // Phase 0 and 1 pin every register to an end of its range; later phases favour
  // short intervals and small arm counts so that the rise counter gets somewhere.
  function automatic pod_pkg::cfg_regs_t draw_settings(int phase);
    pod_pkg::cfg_regs_t s;
    case (phase)
      0: s = '{16'hFFFF, 16'd0, 16'd0, 8'd0, 24'd0, 24'hFFFFFF, 16'd0};
      1: s = '{16'd0, 16'hFFFF, 16'hFFFF, 8'd255, 24'hFFFFFF, 24'd0, 16'hFFFF};
      default: begin
        s.low_flow_limit = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                       : 16'($urandom_range(500, 30000));
        s.high_flow_limit = ($urandom_range(0, 7) == 0) ? 16'd0
                                                        : 16'($urandom_range(30001, 65535));
        s.sample_interval = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
          0: s.rise_arm_count = 8'd0;
          1: s.rise_arm_count = 8'd255;
          default: s.rise_arm_count = 8'($urandom_range(1, 6));
        endcase
        s.slow_rise_threshold = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF
                                                            : 24'($urandom_range(0, 300));
        s.fast_rise_threshold = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF
                                                            : 24'($urandom_range(0, 300));
        s.fast_window = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                    : 16'($urandom_range(0, 40));
      end
    endcase
    return s;
  endfunction

  // Pressure follows a drifting level so rises and falls come in runs.
  logic [SAMPLE_W-1:0] drift = 24'd1000;

  function automatic request_t make_tick();
    request_t rq;
    int       pick;
    rq.motor = 1'b1;
    rq.calib = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 55 && detector_regs.low_flow_limit != 0) begin
      rq.flow = 16'($urandom_range(0, detector_regs.low_flow_limit - 1));
    end else if (pick < 85 && detector_regs.high_flow_limit > detector_regs.low_flow_limit) begin
      rq.flow = 16'($urandom_range(detector_regs.low_flow_limit,
                                   detector_regs.high_flow_limit - 1));
    end else begin
      // noise: any flow, motor off or calibrating now and then
      rq.flow = 16'($urandom);
      rq.motor = 1'($urandom_range(0, 1));
      rq.calib = ($urandom_range(0, 3) == 0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) drift = drift + 24'($urandom_range(1, 40));
    else if (pick < 68) drift = drift;
    else if (pick < 80) drift = drift - 24'($urandom_range(1, 40));
    else if (pick < 92) drift = drift + 24'($urandom_range(0, 600));
    else drift = 24'($urandom);
    rq.pressure = drift;
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: compare against the oldest expectation, stall on its own rhythm
  // ---------------------------------------------------------------------------
  outcome_t want;
  bit       stalling  = 1'b0;
  int       hold_left = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: result with nothing expected, got lock %0b stop %0b hiz %0b",
                 $time, lock_flag, stop_motor, bridge_hiz);
        mismatches++;
      end else begin
        want = pending_flags.pop_front();
        if (lock_flag !== want.lock) begin
          $display("%0t: lock_flag expected %0b got %0b", $time, want.lock, lock_flag);
          mismatches++;
        end
        if (stop_motor !== want.stop) begin
          $display("%0t: stop_motor expected %0b got %0b", $time, want.stop, stop_motor);
          mismatches++;
        end
        if (bridge_hiz !== want.hiz) begin
          $display("%0t: bridge_hiz expected %0b got %0b", $time, want.hiz, bridge_hiz);
          mismatches++;
        end
      end
    end
    // alternate stall and free runs; free runs are sometimes long
    if (hold_left == 0) begin
      stalling = !stalling;
      if (stalling) hold_left = $urandom_range(1, 4);
      else hold_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 10);
    end
    hold_left--;
    out_stall <= stalling;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    request_t           rq;
    pod_pkg::cfg_regs_t s;
    script_row_t        row;
    bit                 writing;
    writing = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      row = SCRIPT[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) settle();
        put_register(row.reg_sel, row.value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_write <= 1'b0;
        writing = 1'b0;
        offer_tick('{row.pressure, row.flow, row.motor, row.calib}, row.typed, row.flags);
      end
    end

    // slow-mode ticks under the widest intervals: neither reaches a compare
    s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd60, 24'd800, 24'd800, 16'd1500};
    apply_settings(s);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        s.sample_interval = 16'hFFFE;
        apply_settings(s);
      end
      for (int k = 0; k < 6; k++) begin
        drift = drift + 24'($urandom_range(1, 8));
        offer_tick('{drift, 16'd100, 1'b1, 1'b0}, 1'b0, '0);
      end
    end

    // long unbroken ramp: the rise counter reaches the arm count and saturates
    s = '{16'hFFFF, 16'hFFFF, 16'd1, 8'd254, 24'd100, 24'd800, 16'd1500};
    apply_settings(s);
    drift = 24'd1000;
    for (int k = 0; k < 560; k++) begin
      drift = drift + 24'($urandom_range(1, 8));
      rq.pressure = drift;
      rq.flow = 16'($urandom_range(0, 16'hFFFE));
      rq.motor = 1'b1;
      rq.calib = 1'b0;
      offer_tick(rq, 1'b0, '0);
    end

    // random phases, each under its own settings
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings(draw_settings(phase));
      for (int k = 0; k < 130; k++) offer_tick(make_tick(), 1'b0, '0);
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("** pump_occlusion_detector_core: PASSED **");
    end else begin
      $display("** pump_occlusion_detector_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/pod_pkg.sv
src/pump_occlusion_detector_core.sv
tb/pump_occlusion_detector_core_test.sv
